FILE: rtl/graph_dfs_preorder_assert.svh
// Assertion macros shared by the graph search RTL.
// GDFS_ASSERT_IMP checks a same-cycle implication.
// GDFS_ASSERT_NXT checks a next-cycle implication.
// Both expect clk and rst_n in scope. ASSERT_OFF compiles them away.
`ifndef GRAPH_DFS_PREORDER_ASSERT_SVH
`define GRAPH_DFS_PREORDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GDFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define GDFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GDFS_ASSERT_IMP(lbl, ante, cons, msg)
`define GDFS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/gdfs_pkg.sv
package gdfs_pkg;

  localparam int NODE_W         = 5;
  localparam int NODES_DEF      = 16;
  localparam int MAX_DEGREE_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    OP_APPEND   = 1'b0,
    OP_TRAVERSE = 1'b1
  } gdfs_op_t;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_DROP = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch input transaction, read source degree
    logic app_commit;  // finish edge append, emit ack
    logic trav_clear;  // clear visit marks
    logic trav_init;   // mark start, push first frame
    logic err_emit;    // emit bad-start result
    logic fetch;       // read degree and neighbor of top frame
    logic advance;     // step top frame position
    logic push;        // step position, push new node, emit pending
    logic pop;         // drop top frame
    logic fin;         // emit pending node as last
  } gdfs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    gdfs_op_t op;
    logic     src_ok;
    logic     out_free;
    logic     stk_empty;
    logic     cap_hit;
    logic     has_next;
    logic     new_node;
  } gdfs_sts_t;

endpackage

FILE: rtl/gdfs_ctrl.sv
`include "graph_dfs_preorder_assert.svh"

module gdfs_ctrl import gdfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gdfs_sts_t sts,
  output gdfs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APP,
    S_TINIT,
    S_FETCH,
    S_EVAL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_TINIT;
        end
      end
      S_TINIT: begin
        if (sts.op == OP_APPEND) begin
          state_nxt = S_APP;
        end else begin
          cmd.trav_clear = 1'b1;
          if (sts.src_ok) begin
            cmd.trav_init = 1'b1;
            state_nxt     = S_FETCH;
          end else if (sts.out_free) begin
            cmd.err_emit = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      S_APP: begin
        if (sts.out_free) begin
          cmd.app_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FETCH: begin
        if (sts.stk_empty || sts.cap_hit) begin
          state_nxt = S_FIN;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!sts.has_next) begin
          cmd.pop   = 1'b1;
          state_nxt = S_FETCH;
        end else if (!sts.new_node) begin
          cmd.advance = 1'b1;
          state_nxt   = S_FETCH;
        end else if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `GDFS_ASSERT_IMP(a_emit_needs_room, cmd.push || cmd.fin || cmd.app_commit || cmd.err_emit, sts.out_free, "result emitted while output slot busy")
  `GDFS_ASSERT_NXT(a_accept_leaves_idle, in_valid && in_ready, !in_ready, "still ready after accepting a transaction")
  `GDFS_ASSERT_NXT(a_fetch_then_eval, cmd.fetch, !in_ready && !cmd.fetch, "fetch not followed by evaluation")

endmodule

FILE: rtl/gdfs_dpath.sv
`include "graph_dfs_preorder_assert.svh"

module gdfs_dpath import gdfs_pkg::*; #(
  parameter int NODES      = NODES_DEF,
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gdfs_cmd_t         cmd,
  output gdfs_sts_t         sts,
  input  logic              in_opcode,
  input  logic [NODE_W-1:0] in_from_node,
  input  logic [NODE_W-1:0] in_to_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_visited_node,
  output logic              out_last,
  output logic              out_status
);

  localparam int NIW   = $clog2(NODES);
  localparam int SDW   = $clog2(NODES + 1);
  localparam int DW    = $clog2(MAX_DEGREE + 1);
  localparam int DEPTH = NODES * MAX_DEGREE;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic [NIW-1:0] node_idx(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] m;
    m = node - NODE_W'(1);
    return NIW'(m);
  endfunction

  function automatic logic node_ok(input logic [NODE_W-1:0] node);
    return (node != '0) && (32'(node) <= 32'(NODES));
  endfunction

  // latched input transaction
  logic              op_r;
  logic [NODE_W-1:0] src_r, dst_r;

  // degree table with per-entry valid bits, registered read
  logic [DW-1:0]     deg_mem [NODES];
  logic [NODES-1:0]  deg_vld_r;
  logic [DW-1:0]     deg_q_r;
  logic              deg_qv_r;
  logic [DW-1:0]     deg_eff;

  // neighbor store, registered read
  logic [NODE_W-1:0] store_mem [DEPTH];
  logic [NODE_W-1:0] store_q_r;

  logic [NODES-1:0]  vis_r;
  logic [NODE_W-1:0] stk_node_r [NODES];
  logic [DW-1:0]     stk_pos_r  [NODES];
  logic [SDW-1:0]    depth_r;
  logic [CNT_W-1:0]  count_r;
  logic [NODE_W-1:0] pend_r;

  logic              out_valid_r, out_last_r, out_status_r;
  logic [NODE_W-1:0] out_node_r;

  logic [NIW-1:0]    top_idx, push_idx, src_idx, rd_idx, t_idx;
  logic [NODE_W-1:0] top_node;
  logic [DW-1:0]     top_pos;
  logic              deg_rd, store_rd, app_bad, emit;
  logic [AW-1:0]     store_wr_addr, store_rd_addr;
  logic [NODE_W-1:0] emit_node;
  logic              emit_last, emit_status;

  assign top_idx  = NIW'(depth_r - SDW'(1));
  assign push_idx = NIW'(depth_r);
  assign src_idx  = node_idx(src_r);
  assign t_idx    = node_idx(store_q_r);
  assign top_node = stk_node_r[top_idx];
  assign top_pos  = stk_pos_r[top_idx];
  assign deg_eff  = deg_qv_r ? deg_q_r : '0;

  assign deg_rd   = cmd.accept || cmd.fetch;
  assign rd_idx   = cmd.accept ? node_idx(in_from_node) : node_idx(top_node);
  assign store_rd = cmd.fetch && (top_pos < DW'(MAX_DEGREE));

  assign store_rd_addr = AW'(node_idx(top_node)) * AW'(MAX_DEGREE) + AW'(top_pos);
  assign store_wr_addr = AW'(src_idx) * AW'(MAX_DEGREE) + AW'(deg_eff);

  assign app_bad = !node_ok(src_r) || !node_ok(dst_r) || (deg_eff >= DW'(MAX_DEGREE));

  assign sts.op        = gdfs_op_t'(op_r);
  assign sts.src_ok    = node_ok(src_r);
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.stk_empty = (depth_r == '0);
  assign sts.cap_hit   = (count_r == CNT_W'(MAX_RESULTS));
  assign sts.has_next  = (top_pos < deg_eff);
  assign sts.new_node  = node_ok(store_q_r) && !vis_r[t_idx] &&
                         (32'(depth_r) < 32'(NODES));

  assign emit = cmd.app_commit || cmd.err_emit || cmd.push || cmd.fin;

  always_comb begin
    emit_node   = '0;
    emit_last   = 1'b1;
    emit_status = ST_OK;
    if (cmd.app_commit) begin
      emit_status = app_bad ? ST_DROP : ST_OK;
    end else if (cmd.err_emit) begin
      emit_status = ST_DROP;
    end else if (cmd.push) begin
      emit_node = pend_r;
      emit_last = 1'b0;
    end else if (cmd.fin) begin
      emit_node = pend_r;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (deg_rd) begin
      deg_q_r  <= deg_mem[rd_idx];
      deg_qv_r <= deg_vld_r[rd_idx];
    end
    if (cmd.app_commit && !app_bad) begin
      deg_mem[src_idx] <= deg_eff + DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (store_rd) begin
      store_q_r <= store_mem[store_rd_addr];
    end
    if (cmd.app_commit && !app_bad) begin
      store_mem[store_wr_addr] <= dst_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_vld_r   <= '0;
      vis_r       <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.app_commit && !app_bad) begin
        deg_vld_r[src_idx] <= 1'b1;
      end
      // clear marks; a good start is marked in the same write
      if (cmd.trav_clear) begin
        vis_r <= cmd.trav_init ? (NODES'(1) << src_idx) : '0;
      end
      if (cmd.trav_init) begin
        depth_r <= SDW'(1);
      end
      if (cmd.push) begin
        vis_r[t_idx] <= 1'b1;
        depth_r      <= depth_r + SDW'(1);
      end
      if (cmd.pop) begin
        depth_r <= depth_r - SDW'(1);
      end
      if (cmd.fin) begin
        depth_r <= '0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_opcode;
      src_r <= in_from_node;
      dst_r <= in_to_node;
    end
    if (cmd.trav_init) begin
      stk_node_r[0] <= src_r;
      stk_pos_r[0]  <= '0;
      count_r       <= CNT_W'(1);
      pend_r        <= src_r;
    end
    if (cmd.advance || cmd.push) begin
      stk_pos_r[top_idx] <= top_pos + DW'(1);
    end
    if (cmd.push) begin
      stk_node_r[push_idx] <= store_q_r;
      stk_pos_r[push_idx]  <= '0;
      count_r              <= count_r + CNT_W'(1);
      pend_r               <= store_q_r;
    end
    if (emit) begin
      out_node_r   <= emit_node;
      out_last_r   <= emit_last;
      out_status_r <= emit_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_visited_node = out_node_r;
  assign out_last         = out_last_r;
  assign out_status       = out_status_r;

  `GDFS_ASSERT_IMP(a_push_room, cmd.push, 32'(depth_r) < 32'(NODES), "push on a full stack")
  `GDFS_ASSERT_IMP(a_fetch_nonempty, cmd.fetch, depth_r != '0, "fetch from an empty stack")
  `GDFS_ASSERT_NXT(a_fin_clears_stack, cmd.fin, depth_r == '0 && out_valid_r, "stack not empty after last result")

endmodule

FILE: rtl/graph_dfs_preorder.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_opcode, in_from_node, in_to_node
// out_      output     out_valid / out_ready  out_visited_node, out_last, out_status
//
// Append: accept, then decode, then commit and result; degree read at acceptance.
// Traversal: init, then fetch/evaluate per stack step, a closing fetch and a final
//   emit; fetch and evaluate are split by the registered table reads.
// Reset (rst_n low, synchronous) clears degree valid bits, visit marks, stack depth
//   and the output slot; the neighbor store needs no clearing pass.
// out_ready low stalls only emitting states; input is taken while a result waits.

module graph_dfs_preorder import gdfs_pkg::*; #(
  parameter int NODES      = NODES_DEF,
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [NODE_W-1:0] in_from_node,
  input  logic [NODE_W-1:0] in_to_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_visited_node,
  output logic              out_last,
  output logic              out_status
);

  // command and status between sequencer and datapath
  gdfs_cmd_t cmd;
  gdfs_sts_t sts;

  // sequencer: accept, append commit, DFS fetch/evaluate loop, final emit
  gdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // graph storage, visit marks, frame stack, pending result and output slot.
  // Each preorder node is held one step so the last flag can be set on it.
  gdfs_dpath #(
    .NODES      (NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_from_node     (in_from_node),
    .in_to_node       (in_to_node),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_visited_node (out_visited_node),
    .out_last         (out_last),
    .out_status       (out_status)
  );

endmodule

FILE: bench/graph_walk_checker.sv
`timescale 1ns / 100ps

module graph_walk_checker import gdfs_pkg::*; #(
  parameter int NODES      = NODES_DEF,
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_opcode,
  input  logic [NODE_W-1:0] in_from_node,
  input  logic [NODE_W-1:0] in_to_node,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [NODE_W-1:0] out_visited_node,
  input  logic              out_last,
  input  logic              out_status,
  output int                fail_count,
  output int                visits_due
);

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    logic              status;
  } visit_t;

  // shadow copy of the graph
  logic [NODE_W-1:0] edge_list [NODES][MAX_DEGREE];
  int unsigned       degree [NODES];

  visit_t expected_visits [$];
  int     errors = 0;

  function automatic bit node_in_range(logic [NODE_W-1:0] n);
    return n >= 1 && n <= NODES;
  endfunction

  function automatic void predict_visits(gdfs_op_t op, logic [NODE_W-1:0] src,
                                         logic [NODE_W-1:0] dst);
    logic              seen [NODES];
    logic [NODE_W-1:0] frame_node [NODES];
    int unsigned       frame_pos [NODES];
    int unsigned       depth;
    int unsigned       top_i;
    int unsigned       cur;
    logic [NODE_W-1:0] nxt;
    visit_t            walk [$];

    if (op == OP_APPEND) begin
      if (!node_in_range(src) || !node_in_range(dst) || degree[src-1] >= MAX_DEGREE) begin
        expected_visits.push_back('{node: '0, last: 1'b1, status: ST_DROP});
      end else begin
        edge_list[src-1][degree[src-1]] = dst;
        degree[src-1]++;
        expected_visits.push_back('{node: '0, last: 1'b1, status: ST_OK});
      end
      return;
    end

    if (!node_in_range(src)) begin
      expected_visits.push_back('{node: '0, last: 1'b1, status: ST_DROP});
      return;
    end

    foreach (seen[i]) seen[i] = 1'b0;
    seen[src-1] = 1'b1;
    walk.push_back('{node: src, last: 1'b0, status: ST_OK});
    frame_node[0] = src;
    frame_pos[0]  = 0;
    depth         = 1;

    // explicit-stack DFS, neighbors tried in append order
    while (depth > 0 && walk.size() < MAX_RESULTS) begin
      top_i = depth - 1;
      cur   = frame_node[top_i] - 1;
      if (frame_pos[top_i] < degree[cur]) begin
        nxt = edge_list[cur][frame_pos[top_i]];
        frame_pos[top_i]++;
        if (!seen[nxt-1] && depth < NODES) begin
          seen[nxt-1] = 1'b1;
          walk.push_back('{node: nxt, last: 1'b0, status: ST_OK});
          frame_node[depth] = nxt;
          frame_pos[depth]  = 0;
          depth++;
        end
      end else begin
        depth--;
      end
    end

    walk[walk.size()-1].last = 1'b1;
    foreach (walk[i]) expected_visits.push_back(walk[i]);
  endfunction

  always @(posedge clk) begin : watch
    visit_t want;
    if (!rst_n) begin
      foreach (degree[i]) degree[i] = 0;
      expected_visits.delete();
    end else begin
      if (in_valid && in_ready)
        predict_visits(gdfs_op_t'(in_opcode), in_from_node, in_to_node);
      if (out_valid && out_ready) begin
        if (expected_visits.size() == 0) begin
          $error("unexpected result: visited_node %0d last %0b status %0b",
                 out_visited_node, out_last, out_status);
          errors++;
        end else begin
          want = expected_visits.pop_front();
          if (out_visited_node !== want.node) begin
            $error("visited_node: expected %0d, got %0d", want.node, out_visited_node);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            errors++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, out_status);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    visits_due <= expected_visits.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the graph DFS block. All checking lives in
// graph_walk_checker; this module only drives traffic and reports.
module tb_top import gdfs_pkg::*; ();

  localparam int NODES        = NODES_DEF;
  localparam int MAX_DEGREE   = MAX_DEGREE_DEF;
  localparam int RANDOM_ITEMS = 470;
  localparam int STEADY_ITEMS = 40;   // opening burst with no idling at all
  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 50;   // settle time after the last result

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic              in_opcode    = OP_APPEND;
  logic [NODE_W-1:0] in_from_node = '0;
  logic [NODE_W-1:0] in_to_node   = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [NODE_W-1:0] out_visited_node;
  logic              out_last;
  logic              out_status;

  int fail_count;
  int visits_due;

  bit steady   = 1'b0;  // both sides run back to back
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  graph_dfs_preorder #(
    .NODES      (NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_from_node     (in_from_node),
    .in_to_node       (in_to_node),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_visited_node (out_visited_node),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  graph_walk_checker #(
    .NODES      (NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) walk_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_from_node     (in_from_node),
    .in_to_node       (in_to_node),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_visited_node (out_visited_node),
    .out_last         (out_last),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .visits_due       (visits_due)
  );

  // Idle length: drawn from a short, a middle or a long range, the short one most often, the long one rarely.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 2);
    if (pick < 94) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Out-of-range node id: zero or anything above NODES in 5 bits.
  function automatic logic [NODE_W-1:0] bad_node();
    if ($urandom_range(0, 3) == 0) return '0;
    return NODE_W'($urandom_range(NODES + 1, (1 << NODE_W) - 1));
  endfunction

  // One input transaction. The gap comes first, so valid stays up between
  // back-to-back transactions and is only ever written once per edge.
  task automatic send_item(gdfs_op_t op, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_from_node <= src;
    in_to_node   <= dst;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random transaction mix: noise, appends biased toward chains (deep
  // stacks), and traversals from random starts.
  task automatic send_random_item();
    int                pick;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      send_item(gdfs_op_t'($urandom_range(0, 1)), bad_node(),
                NODE_W'($urandom_range(0, 31)));
    end else if (pick < 10) begin
      send_item(OP_APPEND, NODE_W'($urandom_range(1, NODES)), bad_node());
    end else if (pick < 62) begin
      src = NODE_W'($urandom_range(1, NODES));
      dst = ($urandom_range(0, 2) == 0) ? NODE_W'((src % NODES) + 1)
                                        : NODE_W'($urandom_range(1, NODES));
      send_item(OP_APPEND, src, dst);
    end else begin
      send_item(OP_TRAVERSE, NODE_W'($urandom_range(1, NODES)),
                NODE_W'($urandom_range(0, 31)));
    end
  endtask

  // Receiver: random ready pattern, one long hold-off on request, and
  // always-ready while the steady burst runs.
  initial begin : receiver
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b0;
        repeat (1 + idle_len()) @(posedge clk);
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #80_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // traversal on an empty graph: start node alone, flagged last
    send_item(OP_TRAVERSE, 5'd1, 5'd0);
    // bad traversal starts
    send_item(OP_TRAVERSE, 5'd0, 5'd31);
    send_item(OP_TRAVERSE, 5'd31, 5'd16);
    // appends with source or target out of range are dropped
    send_item(OP_APPEND, 5'd0, 5'd5);
    send_item(OP_APPEND, 5'd3, 5'd0);
    send_item(OP_APPEND, 5'd4, 5'd31);
    // duplicate edge is stored twice, walk still visits once
    send_item(OP_APPEND, 5'd1, 5'd2);
    send_item(OP_APPEND, 5'd1, 5'd2);
    send_item(OP_TRAVERSE, 5'd1, 5'd17);
    // fill node 16 completely (includes a self loop), then overflow it
    for (int k = 1; k <= MAX_DEGREE; k++)
      send_item(OP_APPEND, 5'd16, 5'(k));
    send_item(OP_APPEND, 5'd16, 5'd5);
    // walk from 16 reaches every node: maximum result count
    send_item(OP_TRAVERSE, 5'd16, 5'd0);

    // --- random ---
    steady = 1'b1;
    for (int i = 0; i < STEADY_ITEMS; i++)
      send_random_item();
    steady = 1'b0;
    // receiver stalls for a long while; sender keeps offering until the
    // block backs up and drops in_ready
    hold_req = 1'b1;
    for (int i = STEADY_ITEMS; i < RANDOM_ITEMS; i++)
      send_random_item();

    in_valid <= 1'b0;
    @(posedge clk);
    while (visits_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/gdfs_pkg.sv
rtl/gdfs_ctrl.sv
rtl/gdfs_dpath.sv
rtl/graph_dfs_preorder.sv
bench/graph_walk_checker.sv
bench/tb_top.sv
